/* hw/rtl/lxc_pkg.sv */
// ----------------------------------------------------------------------------
// lxc_pkg
// Shared widths, chord/step decode table and elaboration-time helpers for
// the lux conversion pipeline.
// ----------------------------------------------------------------------------
package lxc_pkg;

  localparam int RAW_W    = 8;
  localparam int CODE_W   = 7;
  localparam int COUNT_W  = 12;
  localparam int ACC_W    = 32;
  localparam int FACTOR_W = 16;
  localparam int LUX_W    = 11;

  // scale stage constants: f = round(46 * acc / (100 * 2^16))
  localparam int X_W        = 39;
  localparam int Y_W        = 22;
  localparam int P_W        = 45;
  localparam int PROD_W     = 28;
  localparam logic [X_W-1:0] LUX_GAIN   = 39'd46;
  localparam logic [X_W-1:0] ROUND_BIAS = 39'd3276800;
  localparam logic [Y_W-1:0] DEC_DIV    = 22'd100;
  localparam logic [P_W-1:0] DEC_RECIP  = 45'd5368709;
  localparam int RECIP_SHIFT = 29;

  localparam logic [COUNT_W-1:0] CHORD_BASE [8] = '{
    12'd0, 12'd16, 12'd49, 12'd115, 12'd247, 12'd511, 12'd1039, 12'd2095
  };

  typedef struct packed {
    logic zero;
    logic sat;
  } lxc_div_flags_t;

  typedef struct packed {
    logic zero;
    logic one;
  } lxc_pow_flags_t;

  function automatic logic [COUNT_W-1:0] decode_count(input logic [CODE_W-1:0] code);
    logic [2:0]         chord;
    logic [3:0]         step;
    logic [COUNT_W-1:0] offs;
    chord = code[6:4];
    step  = code[3:0];
    offs  = COUNT_W'(step) << chord;
    return CHORD_BASE[chord] + offs;
  endfunction

  function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] p;
    p = a * b + (64'd1 << 31);
    return p >> 32;
  endfunction

  // exp(-3.13 / 2^frac_bits) in Q0.32, Taylor terms 0..12
  function automatic logic [ACC_W-1:0] step_decay(input int frac_bits);
    logic [63:0] y;
    logic [63:0] t;
    logic [63:0] s;
    y = ((64'd313 << (32 - frac_bits)) + 64'd50) / 64'd100;
    t = 64'd1 << 32;
    s = t;
    t = ((t * y) >> 32) / 64'd1;  s = s - t;
    t = ((t * y) >> 32) / 64'd2;  s = s + t;
    t = ((t * y) >> 32) / 64'd3;  s = s - t;
    t = ((t * y) >> 32) / 64'd4;  s = s + t;
    t = ((t * y) >> 32) / 64'd5;  s = s - t;
    t = ((t * y) >> 32) / 64'd6;  s = s + t;
    t = ((t * y) >> 32) / 64'd7;  s = s - t;
    t = ((t * y) >> 32) / 64'd8;  s = s + t;
    t = ((t * y) >> 32) / 64'd9;  s = s - t;
    t = ((t * y) >> 32) / 64'd10; s = s + t;
    t = ((t * y) >> 32) / 64'd11; s = s - t;
    t = ((t * y) >> 32) / 64'd12; s = s + t;
    if (s >= (64'd1 << 32)) begin
      s = (64'd1 << 32) - 64'd1;
    end
    return s[ACC_W-1:0];
  endfunction

  // decay factor squared k times: weight of ratio bit k
  function automatic logic [ACC_W-1:0] pow_base(input int frac_bits, input int k);
    logic [63:0] b;
    b = 64'(step_decay(frac_bits));
    for (int i = 0; i < k; i++) begin
      b = mul_q32(b, b);
    end
    return b[ACC_W-1:0];
  endfunction

endpackage

/* hw/rtl/lxc_if.sv */
// ----------------------------------------------------------------------------
// lxc_if
// Valid/ready channels for raw sensor byte pairs and lux results.
// ----------------------------------------------------------------------------
interface lxc_in_if;
  logic                      valid;
  logic                      ready;
  logic [lxc_pkg::RAW_W-1:0] raw_visible;
  logic [lxc_pkg::RAW_W-1:0] raw_infrared;

  modport source (output valid, output raw_visible, output raw_infrared, input ready);
  modport sink   (input valid, input raw_visible, input raw_infrared, output ready);
endinterface

interface lxc_out_if;
  logic                      valid;
  logic                      ready;
  logic [lxc_pkg::LUX_W-1:0] lux_value;
  logic                      zero_count;

  modport source (output valid, output lux_value, output zero_count, input ready);
  modport sink   (input valid, input lux_value, input zero_count, output ready);
endinterface

/* hw/rtl/lxc_div_cell.sv */
// ----------------------------------------------------------------------------
// lxc_div_cell
// One restoring-division cell: resolves ratio quotient bit IDX.
// ----------------------------------------------------------------------------
module lxc_div_cell #(
  parameter int REM_W = 22,
  parameter int QUO_W = 12,
  parameter int IDX   = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lxc_pkg::COUNT_W-1:0]   in_count0,
  input  logic [REM_W-1:0]              in_rem,
  input  logic [QUO_W-1:0]              in_quo,
  input  lxc_pkg::lxc_div_flags_t       in_flags,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lxc_pkg::COUNT_W-1:0]   out_count0,
  output logic [REM_W-1:0]              out_rem,
  output logic [QUO_W-1:0]              out_quo,
  output lxc_pkg::lxc_div_flags_t       out_flags
);

  localparam int CMP_W = (REM_W > lxc_pkg::COUNT_W + QUO_W) ?
                         REM_W : lxc_pkg::COUNT_W + QUO_W;

  logic                        valid_r;
  logic                        valid_nxt;
  logic                        load;
  logic [CMP_W-1:0]            rem_ext;
  logic [CMP_W-1:0]            dvs;
  logic [lxc_pkg::COUNT_W-1:0] count0_r;
  logic [REM_W-1:0]            rem_r;
  logic [REM_W-1:0]            rem_nxt;
  logic [QUO_W-1:0]            quo_r;
  logic [QUO_W-1:0]            quo_nxt;
  lxc_pkg::lxc_div_flags_t     flags_r;

  assign in_ready  = !valid_r || out_ready;
  assign load      = in_valid && in_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_comb begin
    rem_ext = CMP_W'(in_rem);
    dvs     = CMP_W'(in_count0) << IDX;
    rem_nxt = in_rem;
    quo_nxt = in_quo;
    if (!in_flags.sat && (rem_ext >= dvs)) begin
      rem_nxt      = REM_W'(rem_ext - dvs);
      quo_nxt[IDX] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      count0_r <= in_count0;
      rem_r    <= rem_nxt;
      quo_r    <= quo_nxt;
      flags_r  <= in_flags;
    end
  end

  assign out_valid  = valid_r;
  assign out_count0 = count0_r;
  assign out_rem    = rem_r;
  assign out_quo    = quo_r;
  assign out_flags  = flags_r;

endmodule

/* hw/rtl/lxc_pow_cell.sv */
// ----------------------------------------------------------------------------
// lxc_pow_cell
// One square-and-multiply cell: folds the weight of ratio bit IDX into the
// Q0.32 decay product.
// ----------------------------------------------------------------------------
module lxc_pow_cell #(
  parameter int                          RATIO_W = 12,
  parameter int                          IDX     = 0,
  parameter logic [lxc_pkg::ACC_W-1:0]   BASE    = 32'hFFFF_FFFF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lxc_pkg::COUNT_W-1:0] in_count0,
  input  logic [RATIO_W-1:0]          in_ratio,
  input  logic [lxc_pkg::ACC_W-1:0]   in_acc,
  input  lxc_pkg::lxc_pow_flags_t     in_flags,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lxc_pkg::COUNT_W-1:0] out_count0,
  output logic [RATIO_W-1:0]          out_ratio,
  output logic [lxc_pkg::ACC_W-1:0]   out_acc,
  output lxc_pkg::lxc_pow_flags_t     out_flags
);

  localparam int MUL_W = 2 * lxc_pkg::ACC_W;

  logic                        valid_r;
  logic                        valid_nxt;
  logic                        load;
  logic [MUL_W-1:0]            prod;
  logic [lxc_pkg::COUNT_W-1:0] count0_r;
  logic [RATIO_W-1:0]          ratio_r;
  logic [lxc_pkg::ACC_W-1:0]   acc_r;
  logic [lxc_pkg::ACC_W-1:0]   acc_nxt;
  lxc_pkg::lxc_pow_flags_t     flags_r;
  lxc_pkg::lxc_pow_flags_t     flags_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign load      = in_valid && in_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_comb begin
    prod      = MUL_W'(in_acc) * MUL_W'(BASE) + (MUL_W'(1) << (lxc_pkg::ACC_W - 1));
    acc_nxt   = in_acc;
    flags_nxt = in_flags;
    if (in_ratio[IDX]) begin
      flags_nxt.one = 1'b0;
      if (in_flags.one) begin
        acc_nxt = BASE;
      end else begin
        acc_nxt = prod[MUL_W-1:lxc_pkg::ACC_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      count0_r <= in_count0;
      ratio_r  <= in_ratio;
      acc_r    <= acc_nxt;
      flags_r  <= flags_nxt;
    end
  end

  assign out_valid  = valid_r;
  assign out_count0 = count0_r;
  assign out_ratio  = ratio_r;
  assign out_acc    = acc_r;
  assign out_flags  = flags_r;

endmodule

/* hw/rtl/lxc_scale.sv */
// ----------------------------------------------------------------------------
// lxc_scale
// Four-stage tail: rounds the decay product to the Q0.16 lux factor,
// multiplies by the visible count and holds the result register.
// ----------------------------------------------------------------------------
module lxc_scale (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lxc_pkg::COUNT_W-1:0] in_count0,
  input  logic [lxc_pkg::ACC_W-1:0]   in_acc,
  input  lxc_pkg::lxc_pow_flags_t     in_flags,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lxc_pkg::LUX_W-1:0]   out_lux,
  output logic                        out_zero
);

  localparam int X_W    = lxc_pkg::X_W;
  localparam int Y_W    = lxc_pkg::Y_W;
  localparam int P_W    = lxc_pkg::P_W;
  localparam int F_W    = lxc_pkg::FACTOR_W;
  localparam int C_W    = lxc_pkg::COUNT_W;
  localparam int PROD_W = lxc_pkg::PROD_W;

  logic va_r, vb_r, vc_r, vd_r;
  logic va_nxt, vb_nxt, vc_nxt, vd_nxt;
  logic rdy_a, rdy_b, rdy_c, rdy_d;
  logic load_a, load_b, load_c, load_d;

  logic [X_W-1:0]    x_a;
  logic [Y_W-1:0]    y_a_r;
  logic [C_W-1:0]    c0_a_r;
  logic              z_a_r;

  logic [P_W-1:0]    p_b;
  logic [F_W-1:0]    q_b_r;
  logic [Y_W-1:0]    y_b_r;
  logic [C_W-1:0]    c0_b_r;
  logic              z_b_r;

  logic [Y_W-1:0]    r_c;
  logic [F_W-1:0]    f_c_nxt;
  logic [F_W-1:0]    f_c_r;
  logic [C_W-1:0]    c0_c_r;
  logic              z_c_r;

  logic [PROD_W-1:0]         prod_d;
  logic [lxc_pkg::LUX_W-1:0] lux_d_nxt;
  logic [lxc_pkg::LUX_W-1:0] lux_d_r;
  logic                      zero_d_r;

  assign rdy_d    = !vd_r || out_ready;
  assign rdy_c    = !vc_r || rdy_d;
  assign rdy_b    = !vb_r || rdy_c;
  assign rdy_a    = !va_r || rdy_b;
  assign in_ready = rdy_a;

  assign load_a = in_valid && rdy_a;
  assign load_b = va_r && rdy_b;
  assign load_c = vb_r && rdy_c;
  assign load_d = vc_r && rdy_d;

  assign va_nxt = rdy_a ? in_valid : va_r;
  assign vb_nxt = rdy_b ? va_r : vb_r;
  assign vc_nxt = rdy_c ? vb_r : vc_r;
  assign vd_nxt = rdy_d ? vc_r : vd_r;

  always_comb begin
    x_a     = X_W'({in_flags.one, in_acc}) * lxc_pkg::LUX_GAIN + lxc_pkg::ROUND_BIAS;
    p_b     = P_W'(y_a_r) * lxc_pkg::DEC_RECIP;
    r_c     = y_b_r - Y_W'(Y_W'(q_b_r) * lxc_pkg::DEC_DIV);
    f_c_nxt = (r_c >= lxc_pkg::DEC_DIV) ? F_W'(q_b_r + F_W'(1)) : q_b_r;
    prod_d  = PROD_W'(c0_c_r) * PROD_W'(f_c_r);
    lux_d_nxt = z_c_r ? '0 : prod_d[F_W +: lxc_pkg::LUX_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      va_r <= va_nxt;
      vb_r <= vb_nxt;
      vc_r <= vc_nxt;
      vd_r <= vd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_a) begin
      y_a_r  <= x_a[16 +: Y_W];
      c0_a_r <= in_count0;
      z_a_r  <= in_flags.zero;
    end
    if (load_b) begin
      q_b_r  <= p_b[lxc_pkg::RECIP_SHIFT +: F_W];
      y_b_r  <= y_a_r;
      c0_b_r <= c0_a_r;
      z_b_r  <= z_a_r;
    end
    if (load_c) begin
      f_c_r  <= f_c_nxt;
      c0_c_r <= c0_b_r;
      z_c_r  <= z_b_r;
    end
    if (load_d) begin
      lux_d_r  <= lux_d_nxt;
      zero_d_r <= z_c_r;
    end
  end

  assign out_valid = vd_r;
  assign out_lux   = lux_d_r;
  assign out_zero  = zero_d_r;

endmodule

/* hw/rtl/light_sensor_lux_convert_core.sv */
// ----------------------------------------------------------------------------
// light_sensor_lux_convert_core
// Chord/step light-sensor codes to whole lux, as a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  takes one transaction per pair of raw bytes (raw_visible,
//          raw_infrared); bit 7 of each byte is ignored.
//   out_ch gives one transaction per input: lux_value and zero_count.
//   The path has one decode stage, RATIO_TABLE_BITS division cells (one
//   ratio bit each), RATIO_TABLE_BITS power cells (one 32x32 multiply
//   each) and a four-stage rounding and scaling tail.
//   Throughput is one transaction per cycle while out_ch is ready; every
//   stage holds its own valid bit, so bubbles close up and in_ch stays
//   ready while empty stages remain, even with a result waiting in the
//   output register.
//   A stalled out_ch holds the output register; the stall reaches in_ch only
//   once every stage is full.
//   Reset clears all valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module light_sensor_lux_convert_core #(
  parameter int RATIO_FRAC_BITS  = 10,
  parameter int RATIO_TABLE_BITS = 12
) (
  input  logic      clk,
  input  logic      rst_n,
  lxc_in_if.sink    in_ch,
  lxc_out_if.source out_ch
);

  localparam int C_W   = lxc_pkg::COUNT_W;
  localparam int T     = RATIO_TABLE_BITS;
  localparam int REM_W = C_W + RATIO_FRAC_BITS;
  localparam int CW    = C_W + ((RATIO_FRAC_BITS > T) ? RATIO_FRAC_BITS : T);

  // front decode stage
  logic                      front_v_r;
  logic                      front_v_nxt;
  logic                      front_load;
  logic [C_W-1:0]            c0;
  logic [C_W-1:0]            c1;
  logic [CW-1:0]             num_w;
  logic [CW-1:0]             den_w;
  lxc_pkg::lxc_div_flags_t   flags_nxt;
  logic [C_W-1:0]            c0_r;
  logic [REM_W-1:0]          rem_r;
  logic [T-1:0]              quo_r;
  lxc_pkg::lxc_div_flags_t   flags_r;

  // division chain
  logic                      div_v     [T+1];
  logic                      div_rdy   [T+1];
  logic [C_W-1:0]            div_c0    [T+1];
  logic [REM_W-1:0]          div_rem   [T+1];
  logic [T-1:0]              div_quo   [T+1];
  lxc_pkg::lxc_div_flags_t   div_flags [T+1];

  // power chain
  logic                      pow_v     [T+1];
  logic                      pow_rdy   [T+1];
  logic [C_W-1:0]            pow_c0    [T+1];
  logic [T-1:0]              pow_ratio [T+1];
  logic [lxc_pkg::ACC_W-1:0] pow_acc   [T+1];
  lxc_pkg::lxc_pow_flags_t   pow_flags [T+1];

  always_comb begin
    c0             = lxc_pkg::decode_count(in_ch.raw_visible[lxc_pkg::CODE_W-1:0]);
    c1             = lxc_pkg::decode_count(in_ch.raw_infrared[lxc_pkg::CODE_W-1:0]);
    num_w          = CW'(c1) << RATIO_FRAC_BITS;
    den_w          = CW'(c0) << T;
    flags_nxt.zero = (c0 == '0);
    flags_nxt.sat  = (num_w >= den_w);
  end

  assign in_ch.ready = !front_v_r || div_rdy[0];
  assign front_load  = in_ch.valid && in_ch.ready;
  assign front_v_nxt = in_ch.ready ? in_ch.valid : front_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else begin
      front_v_r <= front_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (front_load) begin
      c0_r    <= c0;
      rem_r   <= REM_W'(num_w);
      quo_r   <= flags_nxt.sat ? '1 : '0;
      flags_r <= flags_nxt;
    end
  end

  assign div_v[0]     = front_v_r;
  assign div_c0[0]    = c0_r;
  assign div_rem[0]   = rem_r;
  assign div_quo[0]   = quo_r;
  assign div_flags[0] = flags_r;

  for (genvar i = 0; i < T; i++) begin : g_div
    lxc_div_cell #(
      .REM_W (REM_W),
      .QUO_W (T),
      .IDX   (T - 1 - i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .in_valid   (div_v[i]),
      .in_ready   (div_rdy[i]),
      .in_count0  (div_c0[i]),
      .in_rem     (div_rem[i]),
      .in_quo     (div_quo[i]),
      .in_flags   (div_flags[i]),
      .out_valid  (div_v[i+1]),
      .out_ready  (div_rdy[i+1]),
      .out_count0 (div_c0[i+1]),
      .out_rem    (div_rem[i+1]),
      .out_quo    (div_quo[i+1]),
      .out_flags  (div_flags[i+1])
    );
  end

  assign pow_v[0]          = div_v[T];
  assign div_rdy[T]        = pow_rdy[0];
  assign pow_c0[0]         = div_c0[T];
  assign pow_ratio[0]      = div_quo[T];
  assign pow_acc[0]        = '0;
  assign pow_flags[0].zero = div_flags[T].zero;
  assign pow_flags[0].one  = 1'b1;

  for (genvar i = 0; i < T; i++) begin : g_pow
    localparam logic [lxc_pkg::ACC_W-1:0] BASE_K = lxc_pkg::pow_base(RATIO_FRAC_BITS, i);
    lxc_pow_cell #(
      .RATIO_W (T),
      .IDX     (i),
      .BASE    (BASE_K)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .in_valid   (pow_v[i]),
      .in_ready   (pow_rdy[i]),
      .in_count0  (pow_c0[i]),
      .in_ratio   (pow_ratio[i]),
      .in_acc     (pow_acc[i]),
      .in_flags   (pow_flags[i]),
      .out_valid  (pow_v[i+1]),
      .out_ready  (pow_rdy[i+1]),
      .out_count0 (pow_c0[i+1]),
      .out_ratio  (pow_ratio[i+1]),
      .out_acc    (pow_acc[i+1]),
      .out_flags  (pow_flags[i+1])
    );
  end

  lxc_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pow_v[T]),
    .in_ready  (pow_rdy[T]),
    .in_count0 (pow_c0[T]),
    .in_acc    (pow_acc[T]),
    .in_flags  (pow_flags[T]),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_lux   (out_ch.lux_value),
    .out_zero  (out_ch.zero_count)
  );

endmodule
